// ===== sv/bch44_pkg.sv =====
// Package for the BCH(44,32) codec: widths, the parity rows, table entry types
// and the parity and syndrome functions.
// Depends on nothing; every other file of the codec imports it.
`timescale 1ns / 1ps

package bch44_pkg;

    localparam int CW_BITS   = 44;
    localparam int DATA_BITS = 32;
    localparam int PAR_BITS  = 12;
    localparam int POS_W     = 6;
    localparam int SYN_DEPTH = 1 << PAR_BITS;

    localparam logic [1:0] ST_CLEAN     = 2'd0;
    localparam logic [1:0] ST_CORRECTED = 2'd1;
    localparam logic [1:0] ST_UNCORR    = 2'd2;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Parity row for message bit 31-r; parity column k sits at bit 11-k.
    localparam logic [PAR_BITS-1:0] PAR_ROW [0:DATA_BITS-1] = '{
        12'hA9C, 12'h54E, 12'h2A7, 12'hBCF, 12'hF7B, 12'hD21, 12'hC0C, 12'h606,
        12'h303, 12'hB1D, 12'hF12, 12'h789, 12'h958, 12'h4AC, 12'h256, 12'h12B,
        12'hA09, 12'hF98, 12'h7CC, 12'h3E6, 12'h1F3, 12'hA65, 12'hFAE, 12'h7D7,
        12'h977, 12'hE27, 12'hD8F, 12'hC5B, 12'hCB1, 12'hCC4, 12'h662, 12'h331
    };

    typedef enum logic [1:0] {
        FIX_NONE,
        FIX_SINGLE,
        FIX_DOUBLE
    } fix_kind_t;

    typedef struct packed {
        fix_kind_t        kind;
        logic [POS_W-1:0] pos_hi;
        logic [POS_W-1:0] pos_lo;
    } fix_entry_t;

    typedef struct packed {
        logic                we;
        logic [PAR_BITS-1:0] addr;
        fix_entry_t          data;
    } map_wr_t;

    typedef enum logic [1:0] {
        INIT_CLEAR,
        INIT_SINGLE,
        INIT_PAIR,
        INIT_DONE
    } init_state_t;

    function automatic logic [PAR_BITS-1:0] rev12(input logic [PAR_BITS-1:0] x);
        logic [PAR_BITS-1:0] r;
        for (int i = 0; i < PAR_BITS; i++)
        begin
            r[PAR_BITS-1-i] = x[i];
        end
        return r;
    endfunction

    function automatic logic [PAR_BITS-1:0] parity_of(input logic [DATA_BITS-1:0] msg);
        logic [PAR_BITS-1:0] p;
        p = '0;
        for (int r = 0; r < DATA_BITS; r++)
        begin
            if (msg[DATA_BITS-1-r])
            begin
                p = p ^ PAR_ROW[r];
            end
        end
        return p;
    endfunction

    function automatic logic [PAR_BITS-1:0] syndrome_of(input logic [CW_BITS-1:0] word);
        return rev12(parity_of(word[CW_BITS-1:PAR_BITS]) ^ word[PAR_BITS-1:0]);
    endfunction

    // Syndrome left by a single error at codeword bit pos.
    function automatic logic [PAR_BITS-1:0] col_syn(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] idx;
        idx = POS_W'(CW_BITS - 1) - pos;
        if (pos >= POS_W'(PAR_BITS))
        begin
            return rev12(PAR_ROW[idx[4:0]]);
        end
        return PAR_BITS'(1) << (POS_W'(PAR_BITS - 1) - pos);
    endfunction

endpackage

// ===== sv/bch44_req_if.sv =====
// Request channel of the BCH(44,32) codec: valid, ready and the request beat.
// Depends on bch44_pkg for the field widths.
`timescale 1ns / 1ps

interface bch44_req_if
    import bch44_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [DATA_BITS-1:0] message;
    logic [CW_BITS-1:0]   received_word;

    modport source (output valid, output req_type, output message,
                    output received_word, input ready);
    modport sink (input valid, input req_type, input message,
                  input received_word, output ready);
endinterface

// ===== sv/bch44_rsp_if.sv =====
// Response channel of the BCH(44,32) codec: valid, ready and the result beat.
// Depends on bch44_pkg for the field widths.
`timescale 1ns / 1ps

interface bch44_rsp_if
    import bch44_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CW_BITS-1:0]  codeword_out;
    logic [PAR_BITS-1:0] syndrome;
    logic [1:0]          status;

    modport source (output valid, output codeword_out, output syndrome,
                    output status, input ready);
    modport sink (input valid, input codeword_out, input syndrome,
                  input status, output ready);
endinterface

// ===== sv/bch44_fill.sv =====
// Start-up sequencer that clears the syndrome table and then writes the
// entry of every one-bit and two-bit error pattern. Depends on bch44_pkg.
`timescale 1ns / 1ps

module bch44_fill
    import bch44_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output map_wr_t wr,
    output logic    done
);

    init_state_t      state_reg, state_next;
    logic [PAR_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [POS_W-1:0] pos_a_reg, pos_a_next;
    logic [POS_W-1:0] pos_b_reg, pos_b_next;

    logic clr_last;
    logic single_last;
    logic pair_row_last;
    logic pair_last;

    assign clr_last      = (clr_addr_reg == {PAR_BITS{1'b1}});
    assign single_last   = (pos_a_reg == POS_W'(CW_BITS - 1));
    assign pair_row_last = (pos_b_reg == POS_W'(CW_BITS - 1));
    assign pair_last     = pair_row_last && (pos_a_reg == POS_W'(CW_BITS - 2));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            INIT_CLEAR:  if (clr_last) state_next = INIT_SINGLE;
            INIT_SINGLE: if (single_last) state_next = INIT_PAIR;
            INIT_PAIR:   if (pair_last) state_next = INIT_DONE;
            INIT_DONE:   state_next = INIT_DONE;
            default:     state_next = INIT_CLEAR;
        endcase
    end

    // Entries are written in the reverse of the search priority, so the
    // pattern that would be tried first is the one left in the table.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        pos_a_next    = pos_a_reg;
        pos_b_next    = pos_b_reg;
        unique case (state_reg)
            INIT_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                pos_a_next    = '0;
            end
            INIT_SINGLE:
            begin
                if (single_last)
                begin
                    pos_a_next = '0;
                    pos_b_next = POS_W'(1);
                end
                else
                begin
                    pos_a_next = pos_a_reg + 1'b1;
                end
            end
            INIT_PAIR:
            begin
                if (pair_row_last)
                begin
                    pos_a_next = pos_a_reg + 1'b1;
                    pos_b_next = pos_a_reg + POS_W'(2);
                end
                else
                begin
                    pos_b_next = pos_b_reg + 1'b1;
                end
            end
            default:
            begin
                clr_addr_next = clr_addr_reg;
            end
        endcase
    end

    always_comb
    begin
        wr.we          = 1'b0;
        wr.addr        = clr_addr_reg;
        wr.data.kind   = FIX_NONE;
        wr.data.pos_hi = pos_a_reg;
        wr.data.pos_lo = pos_a_reg;
        done           = 1'b0;
        unique case (state_reg)
            INIT_CLEAR:
            begin
                wr.we = 1'b1;
            end
            INIT_SINGLE:
            begin
                wr.we        = 1'b1;
                wr.addr      = col_syn(pos_a_reg);
                wr.data.kind = FIX_SINGLE;
            end
            INIT_PAIR:
            begin
                wr.we          = 1'b1;
                wr.addr        = col_syn(pos_a_reg) ^ col_syn(pos_b_reg);
                wr.data.kind   = FIX_DOUBLE;
                wr.data.pos_hi = pos_b_reg;
                wr.data.pos_lo = pos_a_reg;
            end
            INIT_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= INIT_CLEAR;
            clr_addr_reg <= '0;
            pos_a_reg    <= '0;
            pos_b_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pos_a_reg    <= pos_a_next;
            pos_b_reg    <= pos_b_next;
        end
    end

endmodule

// ===== sv/bch44_map.sv =====
// Syndrome table: one entry per syndrome naming the bits to flip, with one
// write port and a registered read port. Depends on bch44_pkg.
`timescale 1ns / 1ps

module bch44_map
    import bch44_pkg::*;
(
    input  logic                clk,
    input  map_wr_t             wr,
    input  logic                rd_en,
    input  logic [PAR_BITS-1:0] rd_addr,
    output fix_entry_t          rd_data
);

    fix_entry_t mem [0:SYN_DEPTH-1];
    fix_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bch_44_32_codec.sv =====
// Shortened BCH(44,32) codec that corrects two bit errors; top level.
// Depends on bch44_pkg, bch44_req_if, bch44_rsp_if, bch44_fill and bch44_map.
// Encoding puts the message in bits 43..12 and the parity in bits 11..0;
// decoding computes the 12-bit syndrome, looks it up in a 4096-entry table
// memory and flips the one or two bits that the table names. One beat is taken
// per cycle unless the response side stalls; the s1 registers hold a request
// while the table read registers its entry, then the output registers take
// the result. Ready stays low after reset while the table is cleared and the
// 44 single-error and 946 double-error entries are written.
`timescale 1ns / 1ps

module bch_44_32_codec
    import bch44_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bch44_req_if.sink   req,
    bch44_rsp_if.source rsp
);

    map_wr_t    map_wr;
    logic       fill_done;
    fix_entry_t entry;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_dec_reg;
    logic [CW_BITS-1:0]  s1_word_reg;
    logic [PAR_BITS-1:0] s1_syn_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CW_BITS-1:0]  out_word_reg, out_word_next;
    logic [PAR_BITS-1:0] out_syn_reg;
    logic [1:0]          out_status_reg, out_status_next;

    logic                accept;
    logic                out_move;
    logic                s1_move;
    logic [PAR_BITS-1:0] syn_in;
    logic [CW_BITS-1:0]  enc_word;
    logic [CW_BITS-1:0]  flip_mask;

    bch44_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (map_wr),
        .done  (fill_done)
    );

    bch44_map u_map (
        .clk     (clk),
        .wr      (map_wr),
        .rd_en   (accept),
        .rd_addr (syn_in),
        .rd_data (entry)
    );

    assign syn_in   = syndrome_of(req.received_word);
    assign enc_word = {req.message, parity_of(req.message)};

    assign out_move  = !out_valid_reg || rsp.ready;
    assign s1_move   = s1_valid_reg && out_move;
    assign req.ready = fill_done && (!s1_valid_reg || out_move);
    assign accept    = req.valid && req.ready;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !rsp.ready);

    always_comb
    begin
        for (int i = 0; i < CW_BITS; i++)
        begin
            flip_mask[i] = (POS_W'(i) == entry.pos_hi)
                || ((entry.kind == FIX_DOUBLE) && (POS_W'(i) == entry.pos_lo));
        end
    end

    always_comb
    begin
        out_word_next   = s1_word_reg;
        out_status_next = ST_CLEAN;
        if ((s1_dec_reg == REQ_DECODE) && (s1_syn_reg != '0))
        begin
            unique case (entry.kind)
                FIX_SINGLE, FIX_DOUBLE:
                begin
                    out_word_next   = s1_word_reg ^ flip_mask;
                    out_status_next = ST_CORRECTED;
                end
                default:
                begin
                    out_status_next = ST_UNCORR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dec_reg <= req.req_type;
            if (req.req_type == REQ_DECODE)
            begin
                s1_word_reg <= req.received_word;
                s1_syn_reg  <= syn_in;
            end
            else
            begin
                s1_word_reg <= enc_word;
                s1_syn_reg  <= '0;
            end
        end
        if (s1_move)
        begin
            out_word_reg   <= out_word_next;
            out_syn_reg    <= s1_syn_reg;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.codeword_out = out_word_reg;
    assign rsp.syndrome     = out_syn_reg;
    assign rsp.status       = out_status_reg;

endmodule

// ===== sv/bch44_checker.sv =====
// Port-level checks for the BCH(44,32) codec, bound to its top level.
// Depends on bch44_pkg and bch_44_32_codec.
`timescale 1ns / 1ps

module bch44_checker
    import bch44_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [CW_BITS-1:0]  codeword_out,
    input logic [PAR_BITS-1:0] syndrome,
    input logic [1:0]          status
);

    // The table is still being built in the first cycle after reset.
    a_no_accept_after_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !in_ready)
        else $error("request ready asserted straight after reset");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(codeword_out)
            && $stable(syndrome) && $stable(status))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_CLEAN) || (status == ST_CORRECTED)
            || (status == ST_UNCORR))
        else $error("result status has no meaning");

    a_clean_iff_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_CLEAN) == (syndrome == '0)))
        else $error("clean status and zero syndrome disagree");

endmodule

bind bch_44_32_codec bch44_checker u_bch44_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .codeword_out (rsp.codeword_out),
    .syndrome     (rsp.syndrome),
    .status       (rsp.status)
);
